FILE: rtl/ffra_pkg.sv
// shared types and constants for the first-fit range allocator
`default_nettype none
package ffra_pkg;
    localparam int OFF_W = 20;
    localparam int CNT_W = 21;
    localparam int SPAN_W = OFF_W + CNT_W;
    localparam logic [CNT_W-1:0] INDEX_SPACE = 21'h100000;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_FIT     = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_BAD_COUNT  = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_BASE = 1'b0;
    localparam logic REG_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] granted_offset;
        logic [CNT_W-1:0] granted_count;
    } t_result;
endpackage
`default_nettype wire

FILE: rtl/ffra_ram.sv
// generic single-port-write, single-read ram with registered read data
`default_nettype none
module ffra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/first_fit_range_allocator.sv
// top level: span table sequencer around one span ram
`default_nettype none
// Each request runs to completion before the next is taken. The span table
// sits in one ram (start and length per entry, one read and one write a
// cycle), walked by a sequencer: a search pass reads spans in order until the
// first fit (allocate) or the insertion point (free), each entry read and then
// checked, then a shift pass moves entries down or up one place, each entry
// read and then written. Search and shift together touch at most MAX_SPANS
// entries, and a request also passes setup and merge steps. The result sits
// in an output register, and the next request is taken only in the cycle
// after that result has been accepted. Reset and a configuration write each
// rebuild the table as one span; entries past the span count are never searched.
module first_fit_range_allocator #(
    parameter int MAX_SPANS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // tdata: range_offset[19:0], range_count[40:20], zero pad [47:41]
    input  wire logic [47:0]  s_axis_tdata,
    // tuser: cmd
    input  wire logic         s_axis_tuser,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: status[1:0], granted_offset[21:2], granted_count[42:22], pad
    output      logic [47:0]  m_axis_tdata,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [20:0]  i_cfg_wdata
);
    import ffra_pkg::*;

    localparam int AW = $clog2(MAX_SPANS);
    localparam int TW = $clog2(MAX_SPANS + 1);
    localparam logic [TW-1:0] MAX_T = TW'(MAX_SPANS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_PREV  = 4'd3;
    localparam logic [3:0] S_PREVW = 4'd4;
    localparam logic [3:0] S_DNRD  = 4'd5;
    localparam logic [3:0] S_DNWR  = 4'd6;
    localparam logic [3:0] S_UPRD  = 4'd7;
    localparam logic [3:0] S_UPWR  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_JOIN  = 4'd10;

    logic [3:0]       r_state;
    logic [OFF_W-1:0] r_base;
    logic [CNT_W-1:0] r_size;
    logic [TW-1:0]    r_total;
    logic             r_cmd;
    logic [OFF_W-1:0] r_off;
    logic [CNT_W-1:0] r_cnt;
    logic [TW-1:0]    r_pos;      // scan position / insertion point, also the shift bound
    logic [TW-1:0]    r_k;
    logic             r_jn;       // free joins following span
    logic [CNT_W-1:0] r_nl;       // length of following span
    logic [SPAN_W-1:0] r_hold;    // split or merged entry written in S_PREVW
    logic [1:0]       r_status;
    t_result          r_res;
    logic             r_ovalid;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [SPAN_W-1:0] wdata, rdata;
    logic [OFF_W-1:0] rd_s;
    logic [CNT_W-1:0] rd_l;
    logic             cfg_hit;
    logic [CNT_W-1:0] room, len0;
    logic [CNT_W:0]   end_f;
    logic [CNT_W-1:0] prev_end;

    ffra_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_SPANS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rd_s = rdata[SPAN_W-1:CNT_W];
    assign rd_l = rdata[CNT_W-1:0];
    // one bit wider so an oversized free cannot wrap
    assign end_f = (CNT_W+1)'(r_off) + (CNT_W+1)'(r_cnt);
    assign prev_end = CNT_W'(rd_s) + rd_l;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid && !i_cfg_we;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_res.granted_count, r_res.granted_offset, r_res.status};

    // rebuilt single span from the registers, with a pending config write applied
    always_comb begin
        logic [OFF_W-1:0] b;
        logic [CNT_W-1:0] s;
        b = r_base;
        s = r_size;
        if (i_cfg_we && i_cfg_index == REG_BASE) b = i_cfg_wdata[OFF_W-1:0];
        if (i_cfg_we && i_cfg_index == REG_SIZE) s = i_cfg_wdata;
        room = INDEX_SPACE - CNT_W'(b);
        len0 = (s < room) ? s : room;
    end
    assign cfg_hit = i_cfg_we;

    // ram port control
    always_comb begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = r_pos[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (cfg_hit) begin
                    we = 1'b1;
                    wdata = {(i_cfg_index == REG_BASE) ? i_cfg_wdata[OFF_W-1:0] : r_base, len0};
                end
                raddr = '0;
            end
            S_PREV: raddr = AW'(r_pos - 1'b1);
            S_PREVW: begin
                we = 1'b1;
                waddr = AW'(r_k);
                wdata = r_hold;
            end
            S_DNRD: raddr = AW'(r_k + 1'b1);
            S_DNWR: begin
                we = 1'b1;
                waddr = AW'(r_k);
                wdata = rdata;
            end
            S_UPRD: raddr = AW'(r_k - 1'b1);
            S_UPWR: begin
                we = 1'b1;
                waddr = AW'(r_k);
                wdata = (r_k == r_pos) ? {r_off, r_cnt} : rdata;
            end
            default: ;
        endcase
        // reset table: one span at base 0 of the reset size
        if (!i_rst_n) begin
            we = 1'b1;
            waddr = '0;
            wdata = {{OFF_W{1'b0}}, 21'd1024};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_size   <= 21'd1024;
            r_total  <= TW'(1);
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (cfg_hit) begin
                        if (i_cfg_index == REG_BASE) r_base <= i_cfg_wdata[OFF_W-1:0];
                        else r_size <= i_cfg_wdata;
                        r_total <= (len0 != '0) ? TW'(1) : '0;
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd <= s_axis_tuser;
                        r_off <= s_axis_tdata[OFF_W-1:0];
                        r_cnt <= s_axis_tdata[SPAN_W-1:OFF_W];
                        r_pos <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // read of entry r_pos issued here; its data is in rdata in S_SCAN
                    if (r_cnt == '0) begin
                        r_status <= ST_BAD_COUNT;
                        r_state <= S_DONE;
                    end else if (r_cmd == CMD_FREE && end_f > (CNT_W+1)'(INDEX_SPACE)) begin
                        r_status <= ST_BAD_COUNT;
                        r_state <= S_DONE;
                    end else if (r_pos >= r_total) begin
                        if (r_cmd == CMD_ALLOC) begin
                            r_status <= ST_NO_FIT;
                            r_state <= S_DONE;
                        end else begin
                            r_jn <= 1'b0;
                            r_state <= S_PREV;
                        end
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (rd_l >= r_cnt) begin
                            r_res.granted_offset <= rd_s;
                            r_status <= ST_OK;
                            r_k <= r_pos;
                            if (rd_l == r_cnt) begin
                                r_total <= r_total - 1'b1;
                                r_state <= S_DNRD;
                            end else begin
                                r_hold <= {rd_s + r_cnt[OFF_W-1:0], rd_l - r_cnt};
                                r_state <= S_PREVW;
                            end
                        end else begin
                            r_pos <= r_pos + 1'b1;
                            r_state <= S_RD;
                        end
                    end else begin
                        if (rd_s <= r_off) begin
                            r_pos <= r_pos + 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_jn <= ((CNT_W+1)'(rd_s) == end_f);
                            r_nl <= rd_l;
                            r_state <= S_PREV;
                        end
                    end
                end
                S_PREV: begin
                    // previous entry read issued this cycle; decide next
                    r_k <= r_pos;
                    r_state <= S_JOIN;
                end
                S_JOIN: begin
                    if (r_pos != '0 && prev_end == CNT_W'(r_off)) begin
                        r_status <= ST_OK;
                        r_k <= r_pos - 1'b1;
                        if (r_jn) begin
                            r_hold <= {rd_s, rd_l + r_cnt + r_nl};
                            r_total <= r_total - 1'b1;
                        end else begin
                            r_hold <= {rd_s, rd_l + r_cnt};
                        end
                        r_state <= S_PREVW;
                    end else if (r_jn) begin
                        r_status <= ST_OK;
                        r_k <= r_pos;
                        r_hold <= {r_off, r_nl + r_cnt};
                        r_state <= S_PREVW;
                    end else if (r_total >= MAX_T) begin
                        r_status <= ST_TABLE_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_status <= ST_OK;
                        r_k <= r_total;
                        r_total <= r_total + 1'b1;
                        r_state <= (r_total == r_pos) ? S_UPWR : S_UPRD;
                    end
                end
                S_PREVW: begin
                    // if a free merged prev with next: remove entry r_pos, else done
                    if (r_cmd == CMD_FREE && r_jn && r_k != r_pos) begin
                        r_k <= r_pos;
                        r_state <= S_DNRD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DNRD: begin
                    if (r_k >= r_total) r_state <= S_DONE;
                    else r_state <= S_DNWR;
                end
                S_DNWR: begin
                    r_k <= r_k + 1'b1;
                    r_state <= S_DNRD;
                end
                S_UPRD: r_state <= S_UPWR;
                S_UPWR: begin
                    if (r_k == r_pos) r_state <= S_DONE;
                    else begin
                        r_k <= r_k - 1'b1;
                        r_state <= (r_k - 1'b1 == r_pos) ? S_UPWR : S_UPRD;
                    end
                end
                S_DONE: begin
                    r_res.status <= r_status;
                    if (!(r_cmd == CMD_ALLOC && r_status == ST_OK)) begin
                        r_res.granted_offset <= '0;
                        r_res.granted_count <= '0;
                    end else begin
                        r_res.granted_count <= r_cnt;
                    end
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
